// ----- src/crbm_pkg.sv -----
// Shared types and constants for the chunked ring buffer manager.
package crbm_pkg;

   localparam int LEN_W  = 13;
   localparam int ADDR_W = 16;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_PUSH_OVER = 2'd1,
      ERR_POP_OVER  = 2'd2
   } err_type;

   typedef struct packed {
      logic              opcode;
      logic [LEN_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]  free_space;
      logic [ADDR_W-1:0] write_address;
      logic [LEN_W-1:0]  data_length;
      logic [ADDR_W-1:0] read_address;
      err_type           error;
   } rsp_type;

endpackage

// ----- src/crbm_core.sv -----
// Buffer state registers and the per-item push and pop update.
module crbm_core
   import crbm_pkg::*;
#(
   parameter int NUM_CHUNKS  = 16,
   parameter int CHUNK_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type item,
   output rsp_type result
);

   // Chunks from the head up to the write chunk are full, the write chunk holds
   // its own fill and every other chunk is empty, so two fill values cover all.
   localparam int IW = $clog2(NUM_CHUNKS);
   localparam int FW = $clog2(CHUNK_BYTES + 1);
   localparam int CW = (FW > LEN_W) ? FW : LEN_W;
   localparam logic [IW-1:0] LAST = IW'(NUM_CHUNKS - 1);
   localparam logic [CW-1:0] FULL = CW'(CHUNK_BYTES);
   localparam logic [31:0]   CB32 = 32'(CHUNK_BYTES);

   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] write_ff, write_in;
   logic [FW-1:0] wfill_ff, wfill_in;
   logic [FW-1:0] roff_ff, roff_in;

   logic [IW-1:0] tail;
   logic [CW-1:0] wfill_x, roff_x, len_x;
   logic [CW-1:0] space, hfill, avail, fill_sum, off_sum;
   logic [CW-1:0] wfill_n, roff_n, space_n, hfill_n, avail_n;
   logic [31:0]   waddr, raddr;
   err_type       err;

   always_comb begin
      wfill_x = CW'(wfill_ff);
      roff_x  = CW'(roff_ff);
      len_x   = CW'(item.length);
      tail    = (head_ff == '0) ? LAST : head_ff - 1'b1;
      space   = (wfill_x >= FULL) ? '0 : FULL - wfill_x;
      hfill   = (head_ff == write_ff) ? wfill_x : FULL;
      avail   = (roff_x >= hfill) ? '0 : hfill - roff_x;
      fill_sum = wfill_x + len_x;
      off_sum  = roff_x + len_x;

      head_in  = head_ff;
      write_in = write_ff;
      wfill_in = wfill_ff;
      roff_in  = roff_ff;
      err      = ERR_NONE;

      if (item.opcode == OP_PUSH) begin
         if (len_x > space) begin
            err = ERR_PUSH_OVER;
         end else if (fill_sum == FULL && write_ff != tail) begin
            write_in = (write_ff == LAST) ? '0 : write_ff + 1'b1;
            wfill_in = '0;
         end else begin
            wfill_in = FW'(fill_sum);
         end
      end else begin
         if (len_x > avail) begin
            err = ERR_POP_OVER;
         end else if (off_sum == hfill && head_ff != write_ff) begin
            head_in = (head_ff == LAST) ? '0 : head_ff + 1'b1;
            roff_in = '0;
         end else begin
            roff_in = FW'(off_sum);
         end
      end

      wfill_n = CW'(wfill_in);
      roff_n  = CW'(roff_in);
      space_n = (wfill_n >= FULL) ? '0 : FULL - wfill_n;
      hfill_n = (head_in == write_in) ? wfill_n : FULL;
      avail_n = (roff_n >= hfill_n) ? '0 : hfill_n - roff_n;
      waddr   = 32'(write_in) * CB32 + 32'(wfill_in);
      raddr   = 32'(head_in) * CB32 + 32'(roff_in);

      result.free_space    = space_n[LEN_W-1:0];
      result.write_address = (space_n == '0) ? '0 : waddr[ADDR_W-1:0];
      result.data_length   = avail_n[LEN_W-1:0];
      result.read_address  = (avail_n == '0) ? '0 : raddr[ADDR_W-1:0];
      result.error         = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         write_ff <= '0;
         wfill_ff <= '0;
         roff_ff  <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         write_ff <= write_in;
         wfill_ff <= wfill_in;
         roff_ff  <= roff_in;
      end
   end

endmodule

// ----- src/chunked_ring_buffer_manager_top.sv -----
// Top level of the chunked ring buffer manager with its result buffering.
//
// The block tracks a byte buffer built from a ring of NUM_CHUNKS chunks of
// CHUNK_BYTES bytes each. Each item on the req_ channel is a push, which commits
// bytes into the write chunk, or a pop, which consumes bytes from the head chunk.
// Every item gives exactly one item on the rsp_ channel that describes the
// buffer after it: free space and write address, readable length and read
// address, and an error code for a length that is too long and was ignored.
// The result is registered at the edge that accepts the item when the output
// register is free. Throughput is one item per cycle while req_stall is low.
// When rsp_stall holds the result, one more item is accepted into a skid
// register, and then req_stall rises until the output drains.
// Reset empties the buffer: all chunks empty, head and write chunk zero, read
// offset zero, and no result pending.
module chunked_ring_buffer_manager_top
   import crbm_pkg::*;
#(
   parameter int NUM_CHUNKS  = 16,
   parameter int CHUNK_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    accept;
   logic    out_free;
   rsp_type result;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff, out_item_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_item_ff, skid_item_in;

   crbm_core #(
      .NUM_CHUNKS  (NUM_CHUNKS),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .result (result)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_item_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

// ----- tb/chunked_ring_buffer_manager_top_tb.sv -----
// Self-checking testbench for the chunked ring buffer manager with random idling on both sides.
module chunked_ring_buffer_manager_top_tb;
   import crbm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH   = 16;
   localparam int CB    = 4096;
   localparam int IDX_W = $clog2(NCH);
   localparam int RANDOM_ITEMS = 1125;

   typedef struct {
      logic [LEN_W-1:0] fill [NCH];
      logic [IDX_W-1:0] head;
      logic [IDX_W-1:0] wr;
      logic [LEN_W-1:0] roff;
   } ring_state_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   req_type        stim_q [$];
   rsp_type        predicted_status_q [$];
   ring_state_type tracked_ring;
   ring_state_type gen_ring;
   rsp_type        gen_last;
   int             mismatches = 0;
   int             results_seen = 0;
   bit             req_taken = 1'b0;
   int             req_gap = 0;
   bit             send_calm = 1'b0;
   int             stall_left = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;
   bit             recv_calm = 1'b0;

   chunked_ring_buffer_manager_top #(
      .NUM_CHUNKS  (NCH),
      .CHUNK_BYTES (CB)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   function automatic void clear_ring(inout ring_state_type s);
      for (int i = 0; i < NCH; i++) begin
         s.fill[i] = '0;
      end
      s.head = '0;
      s.wr   = '0;
      s.roff = '0;
   endfunction

   function automatic rsp_type commit_or_consume(inout ring_state_type s, input req_type r);
      int      space;
      int      avail;
      int      tail;
      int      wa;
      int      ra;
      rsp_type res;
      space = (s.fill[s.wr] >= CB) ? 0 : CB - int'(s.fill[s.wr]);
      avail = (s.roff >= s.fill[s.head]) ? 0 : int'(s.fill[s.head]) - int'(s.roff);
      res.error = ERR_NONE;
      if (r.opcode == OP_PUSH) begin
         if (int'(r.length) > space) begin
            res.error = ERR_PUSH_OVER;
         end else begin
            s.fill[s.wr] = s.fill[s.wr] + r.length;
            tail = (int'(s.head) + NCH - 1) % NCH;
            if (s.fill[s.wr] == CB && int'(s.wr) != tail) begin
               s.wr = IDX_W'((int'(s.wr) + 1) % NCH);
            end
         end
      end else begin
         if (int'(r.length) > avail) begin
            res.error = ERR_POP_OVER;
         end else begin
            s.roff = s.roff + r.length;
            if (s.roff == s.fill[s.head] && s.head != s.wr) begin
               s.fill[s.head] = '0;
               s.head = IDX_W'((int'(s.head) + 1) % NCH);
               s.roff = '0;
            end
         end
      end
      space = (s.fill[s.wr] >= CB) ? 0 : CB - int'(s.fill[s.wr]);
      avail = (s.roff >= s.fill[s.head]) ? 0 : int'(s.fill[s.head]) - int'(s.roff);
      wa = (space == 0) ? 0 : int'(s.wr) * CB + int'(s.fill[s.wr]);
      ra = (avail == 0) ? 0 : int'(s.head) * CB + int'(s.roff);
      res.free_space    = LEN_W'(space);
      res.write_address = ADDR_W'(wa);
      res.data_length   = LEN_W'(avail);
      res.read_address  = ADDR_W'(ra);
      return res;
   endfunction

   function automatic void add_item(logic op, int len);
      req_type it;
      it.opcode = op;
      it.length = LEN_W'(len);
      stim_q.push_back(it);
      gen_last = commit_or_consume(gen_ring, it);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 2);
      end else if (r < 95) begin
         return $urandom_range(3, 8);
      end
      return $urandom_range(15, 40);
   endfunction

   task automatic check_status(input rsp_type exp, input rsp_type got);
      if (got.free_space !== exp.free_space) begin
         $error("free_space: expected %0d, got %0d", exp.free_space, got.free_space);
         mismatches++;
      end
      if (got.write_address !== exp.write_address) begin
         $error("write_address: expected %0d, got %0d", exp.write_address, got.write_address);
         mismatches++;
      end
      if (got.data_length !== exp.data_length) begin
         $error("data_length: expected %0d, got %0d", exp.data_length, got.data_length);
         mismatches++;
      end
      if (got.read_address !== exp.read_address) begin
         $error("read_address: expected %0d, got %0d", exp.read_address, got.read_address);
         mismatches++;
      end
      if (got.error !== exp.error) begin
         $error("error: expected %0d, got %0d", exp.error, got.error);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) begin
         send_calm = !send_calm;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (stim_q.size() > 0) begin
            req_item  <= stim_q.pop_front();
            req_valid <= 1'b1;
            req_gap = (send_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) begin
         recv_calm = !recv_calm;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && results_seen >= 400) begin
         hold_done = 1'b1;
         hold_left = 300;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_left == 0 && !recv_calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) begin
            stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (predicted_status_q.size() == 0) begin
            $error("Result item arrived with no item outstanding.");
            mismatches++;
         end else begin
            check_status(predicted_status_q.pop_front(), rsp_item);
         end
      end
      if (req_taken) begin
         predicted_status_q.push_back(commit_or_consume(tracked_ring, req_item));
      end
   end

   initial begin
      int  op;
      int  limit;
      int  len;
      int  r;
      bit  fill_phase;
      clear_ring(tracked_ring);
      clear_ring(gen_ring);
      gen_last = '0;
      gen_last.free_space = LEN_W'(CB);

      add_item(OP_PUSH, 0);
      add_item(OP_PUSH, CB + 1);
      add_item(OP_POP, 1);
      add_item(OP_POP, 0);
      add_item(OP_PUSH, 8191);
      add_item(OP_PUSH, 100);
      add_item(OP_POP, 100);
      add_item(OP_PUSH, CB - 100);
      add_item(OP_POP, CB - 100);
      for (int i = 0; i < NCH; i++) begin
         add_item(OP_PUSH, CB);
      end
      add_item(OP_PUSH, 0);
      add_item(OP_PUSH, 1);

      fill_phase = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 59) == 0) begin
            fill_phase = !fill_phase;
         end
         op = ($urandom_range(0, 99) < (fill_phase ? 70 : 30)) ? OP_PUSH : OP_POP;
         limit = (op == OP_PUSH) ? int'(gen_last.free_space) : int'(gen_last.data_length);
         r = $urandom_range(0, 99);
         if (r < 25) begin
            len = limit;
         end else if (r < 35 || limit == 0 && r < 85) begin
            len = 0;
         end else if (r < 85) begin
            len = $urandom_range(1, limit);
         end else if (r < 95) begin
            len = limit + 1 + $urandom_range(0, 64);
         end else begin
            len = $urandom_range(0, 8191);
         end
         add_item(op[0], len);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (stim_q.size() != 0 || req_valid || predicted_status_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
src/crbm_pkg.sv
src/crbm_core.sv
src/chunked_ring_buffer_manager_top.sv
tb/chunked_ring_buffer_manager_top_tb.sv
